// ===== hw/rtl/gifpb_pkg.sv =====
// Shared types, constants and codes for the GIF line palette blitter.
package gifpb_pkg;

  // Storage sizes
  localparam int unsigned SegMax     = 32;
  localparam int unsigned PalDepth   = 256;
  localparam int unsigned SEG_AW     = $clog2(SegMax);
  localparam int unsigned SEG_CW     = $clog2(SegMax + 1);
  localparam int unsigned PAL_AW     = (PalDepth > 1) ? $clog2(PalDepth) : 1;

  // Field widths
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned COLOR_W    = 16;
  localparam int unsigned IDX_W      = 8;

  // Bus widths
  localparam int unsigned S_DATA_W   = 96;
  localparam int unsigned M_DATA_W   = 64;
  localparam int unsigned APB_AW     = 3;
  localparam int unsigned APB_DW     = 32;

  // Register reset values
  localparam logic [DIM_W-1:0] DISP_W_RST = 13'd320;
  localparam logic [DIM_W-1:0] DISP_H_RST = 13'd240;

  // Disposal method that restores to background
  localparam logic [2:0] DISPOSE_BG = 3'd2;

  // Input word kinds
  typedef enum logic [1:0] {
    KIND_PAL_WR = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_PIXEL  = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_e;

  // Result word kinds
  typedef enum logic {
    RES_WINDOW = 1'b0,
    RES_COLOR  = 1'b1
  } res_kind_e;

  // Register indexes
  typedef enum logic {
    REG_DISP_W = 1'b0,
    REG_DISP_H = 1'b1
  } reg_idx_e;

  // Control sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_COLOR,
    ST_FLUSH_WIN,
    ST_SEG_RD,
    ST_SEG_PUSH
  } state_e;

  // Panel geometry from the register block
  typedef struct packed {
    logic [DIM_W-1:0] disp_w;
    logic [DIM_W-1:0] disp_h;
  } cfg_t;

endpackage

// ===== hw/rtl/gif_line_palette_blit_top.sv =====
// Top level of the GIF line palette blitter: register block and line sequencer.
//
//  Channel   Dir  Handshake                  Payload
//  s_axis    in   tvalid/tready              tuser: kind; tdata: item fields
//  m_axis    out  tvalid/tready              tuser: result_kind; tlast: last_of_run
//  apb       in   psel/penable/pwrite/pready display_width @0, display_height @4
//
//  Palette write, line header and dropped pixel: handled in the idle state alone.
//  Pixel without transparency: palette lookup, then output (the line's first pixel adds its window command).
//  Opaque pixel with transparency: palette lookup into the run buffer; a run flush
//  sends a window word, then a read of the run buffer for each replayed word.
//  Reset clears the line state; palette and run buffer contents start undefined.
//  A stalled output word holds the sequencer; input is taken only between items.
module gif_line_palette_blit_top
  import gifpb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input words
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [7:0] index_value, [23:8] color565, [39:24] line_x, [55:40] line_y,
  // [71:56] line_width, [79:72] transparent_index, [80] transparency_on,
  // [83:81] disposal_mode, [91:84] background_index, [95:92] zero
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]          s_axis_tuser,
  // Result words
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [15:0] window_x, [31:16] window_y, [47:32] window_count, [63:48] pixel_color
  output logic [M_DATA_W-1:0] m_axis_tdata,
  // [0] result_kind
  output logic                m_axis_tuser,
  output logic                m_axis_tlast,
  // Configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  cfg_t cfg;

  gifpb_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gifpb_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== hw/rtl/gifpb_ram.sv =====
// Generic simple dual-port RAM with registered read.
module gifpb_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/gifpb_cfg.sv =====
// APB register block holding the panel geometry.
module gifpb_cfg
  import gifpb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [DIM_W-1:0] disp_w_q, disp_w_d;
  logic [DIM_W-1:0] disp_h_q, disp_h_d;
  logic             wr_en;
  reg_idx_e         reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = reg_idx_e'(paddr[2]);

  // Register write decode
  always_comb begin
    disp_w_d = disp_w_q;
    disp_h_d = disp_h_q;
    if (wr_en) begin
      case (reg_sel)
        REG_DISP_W: disp_w_d = pwdata[DIM_W-1:0];
        REG_DISP_H: disp_h_d = pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disp_w_q <= DISP_W_RST;
      disp_h_q <= DISP_H_RST;
    end else begin
      disp_w_q <= disp_w_d;
      disp_h_q <= disp_h_d;
    end
  end

  // Read mux
  always_comb begin
    case (reg_sel)
      REG_DISP_W: prdata = {{(APB_DW-DIM_W){1'b0}}, disp_w_q};
      REG_DISP_H: prdata = {{(APB_DW-DIM_W){1'b0}}, disp_h_q};
      default:    prdata = '0;
    endcase
  end

  assign cfg_o.disp_w = disp_w_q;
  assign cfg_o.disp_h = disp_h_q;

endmodule

// ===== hw/rtl/gifpb_ctrl.sv =====
// Line sequencer: header crop, palette lookup, run buffering and result output.
module gifpb_ctrl
  import gifpb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  input  logic [1:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [M_DATA_W-1:0] m_axis_tdata,
  output logic                m_axis_tuser,
  output logic                m_axis_tlast
);

  // Input word fields
  kind_e              in_kind;
  logic [IDX_W-1:0]   in_idx;
  logic [COLOR_W-1:0] in_color;
  logic [COORD_W-1:0] in_x, in_y, in_w;
  logic [IDX_W-1:0]   in_tidx, in_bg;
  logic               in_ton;
  logic [2:0]         in_disp;

  assign in_kind  = kind_e'(s_axis_tuser);
  assign in_idx   = s_axis_tdata[7:0];
  assign in_color = s_axis_tdata[23:8];
  assign in_x     = s_axis_tdata[39:24];
  assign in_y     = s_axis_tdata[55:40];
  assign in_w     = s_axis_tdata[71:56];
  assign in_tidx  = s_axis_tdata[79:72];
  assign in_ton   = s_axis_tdata[80];
  assign in_disp  = s_axis_tdata[83:81];
  assign in_bg    = s_axis_tdata[91:84];

  state_e state_q, state_d;

  // Latched line header and line progress
  logic [COORD_W-1:0] x_q, x_d, y_q, y_d;
  logic [IDX_W-1:0]   tidx_q, tidx_d, bg_q, bg_d;
  logic               dbg_q, dbg_d, ton_q, ton_d, draw_q, draw_d;
  logic [COORD_W-1:0] crop_q, crop_d, pos_q, pos_d;

  // Run buffer bookkeeping
  logic [SEG_CW-1:0]  cnt_q, cnt_d, rdi_q, rdi_d;
  logic [COORD_W-1:0] start_q, start_d;

  // Per-pixel notes carried into the lookup cycle
  logic               first_q, first_d, end_q, end_d, rng_q, rng_d;

  // Output register
  logic               ov_q, ov_d, olast_q, olast_d;
  res_kind_e          okind_q, okind_d;
  logic [COORD_W-1:0] owx_q, owx_d, owy_q, owy_d, owc_q, owc_d;
  logic [COLOR_W-1:0] ocol_q, ocol_d;

  // Memory ports
  logic               pal_we, pal_re, seg_we, seg_re;
  logic [PAL_AW-1:0]  pal_waddr, pal_raddr;
  logic [COLOR_W-1:0] pal_rdata, seg_rdata, pal_color;

  // Decode helpers
  logic               acc, out_free, pix_ok, pix_trans;
  logic [IDX_W-1:0]   map_idx;
  logic [COORD_W:0]   xw_sum;
  logic [COORD_W-1:0] dw16, dh16, hdr_crop;
  logic               hdr_draw;
  logic [SEG_CW-1:0]  cnt_inc, rdi_inc;
  logic [COORD_W-1:0] pos_inc;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign acc           = s_axis_tvalid & s_axis_tready;
  assign out_free      = !ov_q || m_axis_tready;

  // Header crop: one add and compare against the panel width
  assign dw16     = {{(COORD_W-DIM_W){1'b0}}, cfg_i.disp_w};
  assign dh16     = {{(COORD_W-DIM_W){1'b0}}, cfg_i.disp_h};
  assign xw_sum   = {1'b0, in_x} + {1'b0, in_w};
  assign hdr_crop = (xw_sum > {1'b0, dw16}) ? (dw16 - in_x) : in_w;
  assign hdr_draw = (in_y < dh16) && (in_x < dw16) && (hdr_crop != '0);

  // Pixel decode
  assign pix_ok    = draw_q && (pos_q < crop_q);
  assign map_idx   = (dbg_q && (in_idx == tidx_q)) ? bg_q : in_idx;
  assign pix_trans = ton_q && (map_idx == tidx_q);
  assign pos_inc   = pos_q + COORD_W'(1);
  assign cnt_inc   = cnt_q + SEG_CW'(1);
  assign rdi_inc   = rdi_q + SEG_CW'(1);
  assign pal_color = rng_q ? pal_rdata : '0;

  // Palette port addressing
  assign pal_waddr = in_idx[PAL_AW-1:0];
  assign pal_raddr = map_idx[PAL_AW-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc && in_kind == KIND_PIXEL && pix_ok) begin
          if (!pix_trans) begin
            state_d = ST_LOOKUP;
          end else if (cnt_q != '0) begin
            state_d = ST_FLUSH_WIN;
          end
        end
      end
      ST_LOOKUP: begin
        if (ton_q) begin
          state_d = (cnt_inc >= SEG_CW'(SegMax) || end_q) ? ST_FLUSH_WIN : ST_IDLE;
        end else if (out_free) begin
          state_d = first_q ? ST_COLOR : ST_IDLE;
        end
      end
      ST_COLOR: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_FLUSH_WIN: begin
        if (out_free) begin
          state_d = ST_SEG_RD;
        end
      end
      ST_SEG_RD: state_d = ST_SEG_PUSH;
      ST_SEG_PUSH: begin
        if (out_free) begin
          state_d = (rdi_inc == cnt_q) ? ST_IDLE : ST_SEG_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    x_d = x_q;  y_d = y_q;  tidx_d = tidx_q;  bg_d = bg_q;
    dbg_d = dbg_q;  ton_d = ton_q;  draw_d = draw_q;
    crop_d = crop_q;  pos_d = pos_q;
    cnt_d = cnt_q;  rdi_d = rdi_q;  start_d = start_q;
    first_d = first_q;  end_d = end_q;  rng_d = rng_q;
    ov_d = ov_q && !m_axis_tready;
    olast_d = olast_q;  okind_d = okind_q;
    owx_d = owx_q;  owy_d = owy_q;  owc_d = owc_q;  ocol_d = ocol_q;
    pal_we = 1'b0;  pal_re = 1'b0;  seg_we = 1'b0;  seg_re = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          case (in_kind)
            KIND_PAL_WR: begin
              pal_we = ({1'b0, in_idx} < (IDX_W+1)'(PalDepth));
            end
            KIND_HEADER: begin
              x_d     = in_x;
              y_d     = in_y;
              tidx_d  = in_tidx;
              bg_d    = in_bg;
              dbg_d   = (in_disp == DISPOSE_BG);
              ton_d   = in_ton && (in_disp != DISPOSE_BG);
              draw_d  = hdr_draw;
              crop_d  = hdr_draw ? hdr_crop : '0;
              pos_d   = '0;
              cnt_d   = '0;
              start_d = '0;
            end
            KIND_PIXEL: begin
              if (pix_ok) begin
                pos_d   = pos_inc;
                first_d = (pos_q == '0);
                end_d   = (pos_inc >= crop_q);
                if (!pix_trans) begin
                  pal_re = 1'b1;
                  rng_d  = ({1'b0, map_idx} < (IDX_W+1)'(PalDepth));
                  if (ton_q && cnt_q == '0) begin
                    start_d = pos_q;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_LOOKUP: begin
        if (ton_q) begin
          // Opaque pixel joins the pending run
          seg_we = 1'b1;
          cnt_d  = cnt_inc;
        end else if (out_free) begin
          ov_d    = 1'b1;
          owx_d   = first_q ? x_q : '0;
          owy_d   = first_q ? y_q : '0;
          owc_d   = first_q ? crop_q : '0;
          ocol_d  = first_q ? '0 : pal_color;
          okind_d = first_q ? RES_WINDOW : RES_COLOR;
          olast_d = !first_q;
        end
      end
      ST_COLOR: begin
        if (out_free) begin
          ov_d    = 1'b1;
          owx_d   = '0;
          owy_d   = '0;
          owc_d   = '0;
          ocol_d  = pal_color;
          okind_d = RES_COLOR;
          olast_d = 1'b1;
        end
      end
      ST_FLUSH_WIN: begin
        if (out_free) begin
          ov_d    = 1'b1;
          owx_d   = x_q + start_q;
          owy_d   = y_q;
          owc_d   = {{(COORD_W-SEG_CW){1'b0}}, cnt_q};
          ocol_d  = '0;
          okind_d = RES_WINDOW;
          olast_d = 1'b0;
          rdi_d   = '0;
        end
      end
      ST_SEG_RD: seg_re = 1'b1;
      ST_SEG_PUSH: begin
        if (out_free) begin
          ov_d    = 1'b1;
          owx_d   = '0;
          owy_d   = '0;
          owc_d   = '0;
          ocol_d  = seg_rdata;
          okind_d = RES_COLOR;
          olast_d = (rdi_inc == cnt_q);
          rdi_d   = rdi_inc;
          if (rdi_inc == cnt_q) begin
            cnt_d = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      draw_q  <= 1'b0;
      ton_q   <= 1'b0;
      dbg_q   <= 1'b0;
      crop_q  <= '0;
      pos_q   <= '0;
      cnt_q   <= '0;
      start_q <= '0;
      rdi_q   <= '0;
      ov_q    <= 1'b0;
      x_q     <= '0;
      y_q     <= '0;
      tidx_q  <= '0;
      bg_q    <= '0;
    end else begin
      state_q <= state_d;
      draw_q  <= draw_d;
      ton_q   <= ton_d;
      dbg_q   <= dbg_d;
      crop_q  <= crop_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      start_q <= start_d;
      rdi_q   <= rdi_d;
      ov_q    <= ov_d;
      x_q     <= x_d;
      y_q     <= y_d;
      tidx_q  <= tidx_d;
      bg_q    <= bg_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    end_q   <= end_d;
    rng_q   <= rng_d;
    olast_q <= olast_d;
    okind_q <= okind_d;
    owx_q   <= owx_d;
    owy_q   <= owy_d;
    owc_q   <= owc_d;
    ocol_q  <= ocol_d;
  end

  // Palette memory
  gifpb_ram #(
    .DEPTH (PalDepth),
    .WIDTH (COLOR_W)
  ) u_pal (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (pal_waddr),
    .wdata_i (in_color),
    .re_i    (pal_re),
    .raddr_i (pal_raddr),
    .rdata_o (pal_rdata)
  );

  // Opaque run buffer
  gifpb_ram #(
    .DEPTH (SegMax),
    .WIDTH (COLOR_W)
  ) u_seg (
    .clk_i   (clk_i),
    .we_i    (seg_we),
    .waddr_i (cnt_q[SEG_AW-1:0]),
    .wdata_i (pal_color),
    .re_i    (seg_re),
    .raddr_i (rdi_q[SEG_AW-1:0]),
    .rdata_o (seg_rdata)
  );

  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = okind_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {ocol_q, owc_q, owy_q, owx_q};

  // Run length never exceeds the buffer
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= SEG_CW'(SegMax))
    else $error("run count past buffer size");

  // Line progress stays within the cropped width
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= crop_q)
    else $error("pixel position past cropped width");

  // An undrawable line has nothing to draw
  a_undraw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !draw_q |-> (crop_q == '0))
    else $error("undrawable line with nonzero width");

  // A run is flushed only when it holds pixels
  a_flush_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH_WIN || state_q == ST_SEG_RD || state_q == ST_SEG_PUSH)
      |-> (cnt_q != '0))
    else $error("flush of empty run");

  // Buffer replay reads only filled entries
  a_replay_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEG_RD) |-> (rdi_q < cnt_q))
    else $error("replay index past run length");

endmodule
